// ----- rtl/sh_degree3_color_eval_assert.svh -----
// Assertion macros used by the checker file of the color evaluator.
`ifndef SH_DEGREE3_COLOR_EVAL_ASSERT_SVH
`define SH_DEGREE3_COLOR_EVAL_ASSERT_SVH

// Antecedent in one cycle implies the consequent in the next, skipped in reset.
`define SH3CE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sh3ce check failed");

// Consequent must hold in the cycle after reset is seen.
`define SH3CE_ASSERT_AFTER_RESET(lbl, clk, rst, cons) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("sh3ce reset check failed");

`endif

// ----- rtl/sh3ce_pkg.sv -----
`default_nettype none
package sh3ce_pkg;

   localparam int SH_DEGREE_DEF   = 3;
   localparam int QUEUE_DEPTH_DEF = 4;

   localparam int IDX_W      = 4;
   localparam int COEF_W     = 16;
   localparam int POS_W      = 32;
   localparam int DIR_W      = 16;
   localparam int SUM_W      = 32;
   localparam int COLOR_W    = 16;
   localparam int K_W        = 34;
   localparam int INNER_W    = 36;
   localparam int POLY_W     = 38;
   localparam int BASIS_W    = 36;
   localparam int REQ_DATA_W = 152;
   localparam int RSP_DATA_W = 48;
   localparam int CSR_ADDR_W = 2;

   localparam logic [CSR_ADDR_W-1:0] CSR_CAM_X = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CAM_Y = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CAM_Z = 2'd2;

   // One coefficient on its way from the front to the back
   typedef struct packed {
      logic [IDX_W-1:0]         idx;
      logic signed [COEF_W-1:0] coef_r;
      logic signed [COEF_W-1:0] coef_g;
      logic signed [COEF_W-1:0] coef_b;
      logic signed [DIR_W-1:0]  dir_x;
      logic signed [DIR_W-1:0]  dir_y;
      logic signed [DIR_W-1:0]  dir_z;
      logic                     zero_dir;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      FR_IDLE, FR_NORM, FR_SQ, FR_ROOT, FR_DSET, FR_DIV, FR_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      BK_IDLE, BK_SQR, BK_INNER, BK_POLY, BK_KLO, BK_KHI, BK_BASIS, BK_ACC, BK_EMIT
   } back_state_type;

   // Basis scale factors, Q.30
   function automatic logic signed [K_W-1:0] k_coef(input logic [IDX_W-1:0] idx);
      logic signed [K_W-1:0] k;
      case (idx)
         4'd0:    k = 34'sd302896976;
         4'd1:    k = -34'sd524632952;
         4'd2:    k = 34'sd524632952;
         4'd3:    k = -34'sd524632952;
         4'd4:    k = 34'sd1173114945;
         4'd5:    k = -34'sd1173114945;
         4'd6:    k = 34'sd338649115;
         4'd7:    k = -34'sd1173114945;
         4'd8:    k = 34'sd586557472;
         4'd9:    k = -34'sd633554481;
         4'd10:   k = 34'sd3103770403;
         4'd11:   k = -34'sd490749190;
         4'd12:   k = 34'sd400695036;
         4'd13:   k = -34'sd490749190;
         4'd14:   k = 34'sd1551885202;
         default: k = -34'sd633554481;
      endcase
      return k;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/sh3ce_queue.sv -----
`default_nettype none
module sh3ce_queue #(
   parameter int DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push_valid,
   input  sh3ce_pkg::entry_type         push_entry,
   input  logic                         pop,
   output sh3ce_pkg::entry_type         pop_entry,
   output sh3ce_pkg::queue_status_type  status
);
   import sh3ce_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type       mem_ff [DEPTH];
   logic [AW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            do_push, do_pop;
   logic            is_full, is_empty;

   assign is_full   = (cnt_ff == CW'(DEPTH));
   assign is_empty  = (cnt_ff == '0);
   assign status    = '{full: is_full, empty: is_empty};
   assign do_push   = push_valid && !is_full;
   assign do_pop    = pop && !is_empty;
   assign pop_entry = mem_ff[rd_ff];

   // Advance pointers with wrap, track fill level
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      if (do_pop)  rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      else if (do_pop && !do_push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_entry;
   end

endmodule
`default_nettype wire

// ----- rtl/sh3ce_front.sv -----
`default_nettype none
module sh3ce_front #(
   parameter int SH_DEGREE = 3
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic signed [sh3ce_pkg::POS_W-1:0]     cam_x,
   input  logic signed [sh3ce_pkg::POS_W-1:0]     cam_y,
   input  logic signed [sh3ce_pkg::POS_W-1:0]     cam_z,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [sh3ce_pkg::POS_W-1:0]     pos_x,
   input  logic signed [sh3ce_pkg::POS_W-1:0]     pos_y,
   input  logic signed [sh3ce_pkg::POS_W-1:0]     pos_z,
   input  logic [sh3ce_pkg::IDX_W-1:0]            coef_index,
   input  logic signed [sh3ce_pkg::COEF_W-1:0]    coef_r,
   input  logic signed [sh3ce_pkg::COEF_W-1:0]    coef_g,
   input  logic signed [sh3ce_pkg::COEF_W-1:0]    coef_b,
   output logic                                   push_valid,
   output sh3ce_pkg::entry_type                   push_entry,
   input  sh3ce_pkg::queue_status_type            q_status
);
   import sh3ce_pkg::*;

   localparam int LAST = (SH_DEGREE + 1) * (SH_DEGREE + 1) - 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LAST);

   front_state_type         state_ff, state_in;
   logic [32:0]             a_ff [3];
   logic [32:0]             a_in [3];
   logic                    neg_ff [3];
   logic                    neg_in [3];
   logic signed [DIR_W-1:0] dir_ff [3];
   logic signed [DIR_W-1:0] dir_in [3];
   entry_type               ent_ff, ent_in;
   logic                    zero_ff, zero_in;
   logic [63:0]             sq_ff, sq_in;
   logic [1:0]              axis_ff, axis_in;
   logic [63:0]             n_ff, n_in, r_ff, r_in, bit_ff, bit_in;
   logic [46:0]             num_ff, num_in, dsh_ff, dsh_in;
   logic [3:0]              cnt_ff, cnt_in;
   logic [15:0]             q_ff, q_in;

   logic signed [32:0]      d [3];
   logic [32:0]             abs_d [3];
   logic                    accept, any_big, any_29, all_zero, ge;
   logic [29:0]             a_sel;
   logic [59:0]             sq_term;
   logic [63:0]             sq_sum, rb;
   logic [15:0]             q_new, q_sat;

   // Offset from camera and its magnitude per axis
   assign d[0] = {pos_x[POS_W-1], pos_x} - {cam_x[POS_W-1], cam_x};
   assign d[1] = {pos_y[POS_W-1], pos_y} - {cam_y[POS_W-1], cam_y};
   assign d[2] = {pos_z[POS_W-1], pos_z} - {cam_z[POS_W-1], cam_z};
   always_comb begin
      for (int i = 0; i < 3; i++) abs_d[i] = d[i][32] ? 33'(-d[i]) : 33'(d[i]);
   end

   assign accept   = req_valid && req_ready;
   assign any_big  = (|a_ff[0][32:30]) | (|a_ff[1][32:30]) | (|a_ff[2][32:30]);
   assign any_29   = a_ff[0][29] | a_ff[1][29] | a_ff[2][29];
   assign all_zero = (a_ff[0] == '0) && (a_ff[1] == '0) && (a_ff[2] == '0);
   assign a_sel    = a_ff[axis_ff][29:0];
   assign sq_term  = a_sel * a_sel;
   assign sq_sum   = sq_ff + 64'(sq_term);
   assign rb       = r_ff + bit_ff;
   assign ge       = (num_ff >= dsh_ff);
   assign q_new    = q_ff | (ge ? (16'd1 << cnt_ff) : 16'd0);
   assign q_sat    = (q_new > 16'd32767) ? 16'd32767 : q_new;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FR_IDLE: if (accept && coef_index == '0) state_in = FR_NORM;
         FR_NORM: begin
            if (all_zero) state_in = FR_PUSH;
            else if (!any_big && any_29) state_in = FR_SQ;
         end
         FR_SQ:   if (axis_ff == 2'd2) state_in = FR_ROOT;
         FR_ROOT: if (bit_ff == 64'd1) state_in = FR_DSET;
         FR_DSET: state_in = FR_DIV;
         FR_DIV:  if (cnt_ff == '0) state_in = (axis_ff == 2'd2) ? FR_PUSH : FR_DSET;
         FR_PUSH: if (!q_status.full) state_in = FR_IDLE;
         default: state_in = FR_IDLE;
      endcase
   end

   // Handshake and queue writes
   always_comb begin
      req_ready  = 1'b0;
      push_valid = 1'b0;
      push_entry = ent_ff;
      push_entry.dir_x    = dir_ff[0];
      push_entry.dir_y    = dir_ff[1];
      push_entry.dir_z    = dir_ff[2];
      push_entry.zero_dir = zero_ff;
      unique case (state_ff)
         FR_IDLE: begin
            req_ready  = !q_status.full;
            push_valid = accept && coef_index != '0 && coef_index <= LAST_IDX;
            push_entry = '{idx: coef_index, coef_r: coef_r, coef_g: coef_g,
                           coef_b: coef_b, dir_x: '0, dir_y: '0, dir_z: '0,
                           zero_dir: 1'b0};
         end
         FR_PUSH: push_valid = !q_status.full;
         default: ;
      endcase
   end

   // Direction datapath: shift to range, sum squares, root, divide
   always_comb begin
      a_in = a_ff;  neg_in = neg_ff;  dir_in = dir_ff;  ent_in = ent_ff;
      zero_in = zero_ff;  sq_in = sq_ff;  axis_in = axis_ff;
      n_in = n_ff;  r_in = r_ff;  bit_in = bit_ff;
      num_in = num_ff;  dsh_in = dsh_ff;  cnt_in = cnt_ff;  q_in = q_ff;
      case (state_ff)
         FR_IDLE: if (accept && coef_index == '0) begin
            for (int i = 0; i < 3; i++) begin
               a_in[i]   = abs_d[i];
               neg_in[i] = d[i][32];
            end
            ent_in = '{idx: coef_index, coef_r: coef_r, coef_g: coef_g, coef_b: coef_b,
                       dir_x: '0, dir_y: '0, dir_z: '0, zero_dir: 1'b0};
         end
         FR_NORM: begin
            if (all_zero) begin
               for (int i = 0; i < 3; i++) dir_in[i] = '0;
               zero_in = 1'b1;
            end else if (any_big) begin
               for (int i = 0; i < 3; i++) a_in[i] = a_ff[i] >> 1;
            end else if (!any_29) begin
               for (int i = 0; i < 3; i++) a_in[i] = a_ff[i] << 1;
            end else begin
               zero_in = 1'b0;
               sq_in   = '0;
               axis_in = '0;
            end
         end
         FR_SQ: begin
            sq_in   = sq_sum;
            axis_in = axis_ff + 1'b1;
            if (axis_ff == 2'd2) begin
               n_in   = sq_sum;
               r_in   = '0;
               bit_in = 64'd1 << 62;
            end
         end
         FR_ROOT: begin
            if (n_ff >= rb) begin
               n_in = n_ff - rb;
               r_in = (r_ff >> 1) + bit_ff;
            end else begin
               r_in = r_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            axis_in = '0;
         end
         FR_DSET: begin
            num_in = 47'({a_sel, 15'd0}) + 47'(r_ff[30:1]);
            dsh_in = {1'b0, r_ff[30:0], 15'd0};
            cnt_in = 4'd15;
            q_in   = '0;
         end
         FR_DIV: begin
            if (ge) num_in = num_ff - dsh_ff;
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff - 1'b1;
            q_in   = q_new;
            if (cnt_ff == '0) begin
               dir_in[axis_ff] = neg_ff[axis_ff] ? -$signed(q_sat) : $signed(q_sat);
               axis_in = axis_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= FR_IDLE;
      else       state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;  neg_ff <= neg_in;  dir_ff <= dir_in;  ent_ff <= ent_in;
      zero_ff <= zero_in;  sq_ff <= sq_in;  axis_ff <= axis_in;
      n_ff <= n_in;  r_ff <= r_in;  bit_ff <= bit_in;
      num_ff <= num_in;  dsh_ff <= dsh_in;  cnt_ff <= cnt_in;  q_ff <= q_in;
   end

endmodule
`default_nettype wire

// ----- rtl/sh3ce_back.sv -----
`default_nettype none
module sh3ce_back #(
   parameter int SH_DEGREE = 3
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sh3ce_pkg::entry_type                pop_entry,
   input  sh3ce_pkg::queue_status_type         q_status,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [sh3ce_pkg::COLOR_W-1:0]       color_r,
   output logic [sh3ce_pkg::COLOR_W-1:0]       color_g,
   output logic [sh3ce_pkg::COLOR_W-1:0]       color_b,
   output logic                                zero_direction
);
   import sh3ce_pkg::*;

   localparam int LAST = (SH_DEGREE + 1) * (SH_DEGREE + 1) - 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LAST);

   back_state_type            state_ff, state_in;
   entry_type                 cur_ff, cur_in;
   logic signed [DIR_W-1:0]   vd_ff [3];
   logic signed [DIR_W-1:0]   vd_in [3];
   logic                      flag_ff, flag_in;
   logic signed [SUM_W-1:0]   sum_ff [3];
   logic signed [SUM_W-1:0]   sum_in [3];
   logic signed [31:0]        xx_ff, yy_ff, zz_ff, xy_ff, yz_ff, xz_ff;
   logic signed [31:0]        xx_in, yy_in, zz_in, xy_in, yz_in, xz_in;
   logic signed [INNER_W-1:0] inner_ff, inner_in;
   logic signed [DIR_W-1:0]   fac_ff, fac_in;
   logic signed [POLY_W-1:0]  p_ff, p_in;
   logic signed [53:0]        pp_ff, pp_in;
   logic signed [71:0]        kp_ff, kp_in;
   logic signed [BASIS_W-1:0] basis_ff, basis_in;
   logic                      rv_ff, rv_in, zd_ff, zd_in;
   logic [COLOR_W-1:0]        col_ff [3];
   logic [COLOR_W-1:0]        col_in [3];

   logic                      load, out_free;
   logic signed [K_W-1:0]     k;
   logic signed [INNER_W-1:0] xx36, yy36, zz36;
   logic signed [51:0]        p3;
   logic signed [52:0]        khi;
   logic signed [71:0]        kp_rnd;
   logic signed [COEF_W-1:0]  coef [3];
   logic signed [51:0]        cb [3];
   logic signed [21:0]        contrib [3];
   logic signed [33:0]        s [3];
   logic signed [33:0]        v [3];

   assign out_free = !rv_ff || rsp_ready;
   assign k        = k_coef(cur_ff.idx);
   assign xx36     = INNER_W'(xx_ff);
   assign yy36     = INNER_W'(yy_ff);
   assign zz36     = INNER_W'(zz_ff);
   assign coef[0]  = cur_ff.coef_r;
   assign coef[1]  = cur_ff.coef_g;
   assign coef[2]  = cur_ff.coef_b;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:  if (!q_status.empty)
                      state_in = (pop_entry.idx == '0) ? BK_ACC : BK_SQR;
         BK_SQR:   state_in = BK_INNER;
         BK_INNER: state_in = BK_POLY;
         BK_POLY:  state_in = BK_KLO;
         BK_KLO:   state_in = BK_KHI;
         BK_KHI:   state_in = BK_BASIS;
         BK_BASIS: state_in = BK_ACC;
         BK_ACC:   state_in = (cur_ff.idx == LAST_IDX) ? BK_EMIT : BK_IDLE;
         BK_EMIT:  if (out_free) state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   // Queue pop and result load
   always_comb begin
      pop  = 1'b0;
      load = 1'b0;
      unique case (state_ff)
         BK_IDLE: pop  = !q_status.empty;
         BK_EMIT: load = out_free;
         default: ;
      endcase
   end

   // Basis and accumulation datapath
   always_comb begin
      cur_in = cur_ff;  vd_in = vd_ff;  flag_in = flag_ff;  sum_in = sum_ff;
      xx_in = xx_ff;  yy_in = yy_ff;  zz_in = zz_ff;
      xy_in = xy_ff;  yz_in = yz_ff;  xz_in = xz_ff;
      inner_in = inner_ff;  fac_in = fac_ff;  p_in = p_ff;
      pp_in = pp_ff;  kp_in = kp_ff;  basis_in = basis_ff;
      p3 = '0;  khi = '0;  kp_rnd = '0;
      for (int c = 0; c < 3; c++) begin
         cb[c]      = coef[c] * basis_ff;
         contrib[c] = 22'((cb[c] + 52'sd536870912) >>> 30);
         s[c]       = 34'(sum_ff[c]) + 34'(contrib[c]);
      end
      case (state_ff)
         BK_IDLE: if (!q_status.empty) begin
            cur_in = pop_entry;
            if (pop_entry.idx == '0) begin
               vd_in[0] = pop_entry.dir_x;
               vd_in[1] = pop_entry.dir_y;
               vd_in[2] = pop_entry.dir_z;
               flag_in  = pop_entry.zero_dir;
               for (int c = 0; c < 3; c++) sum_in[c] = '0;
               basis_in = BASIS_W'(k_coef(pop_entry.idx));
            end
         end
         BK_SQR: begin
            xx_in = vd_ff[0] * vd_ff[0];
            yy_in = vd_ff[1] * vd_ff[1];
            zz_in = vd_ff[2] * vd_ff[2];
            xy_in = vd_ff[0] * vd_ff[1];
            yz_in = vd_ff[1] * vd_ff[2];
            xz_in = vd_ff[0] * vd_ff[2];
         end
         BK_INNER: begin
            case (cur_ff.idx) inside
               4'd4, 4'd10: inner_in = INNER_W'(xy_ff);
               4'd5:        inner_in = INNER_W'(yz_ff);
               4'd6:        inner_in = (zz36 <<< 1) - xx36 - yy36;
               4'd7:        inner_in = INNER_W'(xz_ff);
               4'd8, 4'd14: inner_in = xx36 - yy36;
               4'd9:        inner_in = (xx36 <<< 1) + xx36 - yy36;
               4'd11, 4'd13: inner_in = (zz36 <<< 2) - xx36 - yy36;
               4'd12:       inner_in = (zz36 <<< 1) - (xx36 <<< 1) - xx36
                                       - (yy36 <<< 1) - yy36;
               default:     inner_in = xx36 - (yy36 <<< 1) - yy36;
            endcase
            case (cur_ff.idx) inside
               4'd1, 4'd9, 4'd11:         fac_in = vd_ff[1];
               4'd2, 4'd10, 4'd12, 4'd14: fac_in = vd_ff[2];
               default:                   fac_in = vd_ff[0];
            endcase
         end
         BK_POLY: begin
            p3 = fac_ff * inner_ff;
            case (cur_ff.idx) inside
               4'd1, 4'd2, 4'd3:             p_in = POLY_W'(fac_ff) <<< 15;
               4'd4, 4'd5, 4'd6, 4'd7, 4'd8: p_in = POLY_W'(inner_ff);
               default: p_in = POLY_W'((p3 + 52'sd16384) >>> 15);
            endcase
         end
         BK_KLO: pp_in = k * $signed({1'b0, p_ff[18:0]});
         BK_KHI: begin
            khi   = k * $signed(p_ff[POLY_W-1:19]);
            kp_in = 72'(pp_ff) + (72'(khi) <<< 19);
         end
         BK_BASIS: begin
            kp_rnd   = kp_ff + 72'sd536870912;
            basis_in = BASIS_W'(kp_rnd >>> 30);
         end
         BK_ACC: begin
            for (int c = 0; c < 3; c++) begin
               if (s[c] > 34'sd2147483647)       sum_in[c] = 32'sh7fffffff;
               else if (s[c] < -34'sd2147483648) sum_in[c] = 32'sh80000000;
               else                              sum_in[c] = SUM_W'(s[c]);
            end
         end
         default: ;
      endcase
   end

   // Output register: add half, clamp, hold until taken
   always_comb begin
      rv_in = rv_ff;
      zd_in = zd_ff;
      col_in = col_ff;
      for (int c = 0; c < 3; c++) v[c] = 34'(sum_ff[c]) + 34'sd2048;
      if (rsp_ready) rv_in = 1'b0;
      if (load) begin
         rv_in = 1'b1;
         zd_in = flag_ff;
         for (int c = 0; c < 3; c++) begin
            if (v[c] < 34'sd0)          col_in[c] = '0;
            else if (v[c] > 34'sd65535) col_in[c] = 16'hffff;
            else                        col_in[c] = COLOR_W'(v[c]);
         end
      end
   end

   assign rsp_valid      = rv_ff;
   assign color_r        = col_ff[0];
   assign color_g        = col_ff[1];
   assign color_b        = col_ff[2];
   assign zero_direction = zd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         rv_ff    <= 1'b0;
         flag_ff  <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            vd_ff[i]  <= '0;
            sum_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         flag_ff  <= flag_in;
         vd_ff    <= vd_in;
         sum_ff   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      xx_ff <= xx_in;  yy_ff <= yy_in;  zz_ff <= zz_in;
      xy_ff <= xy_in;  yz_ff <= yz_in;  xz_ff <= xz_in;
      inner_ff <= inner_in;  fac_ff <= fac_in;  p_ff <= p_in;
      pp_ff <= pp_in;  kp_ff <= kp_in;  basis_ff <= basis_in;
      zd_ff <= zd_in;  col_ff <= col_in;
   end

endmodule
`default_nettype wire

// ----- rtl/sh_degree3_color_eval.sv -----
`default_nettype none
// Channel | Ports   | Payload
// request | req_*   | tdata: pos_x, pos_y, pos_z, coef_index, coef_r, coef_g, coef_b
// result  | rsp_*   | tdata: color_r, color_g, color_b; tuser: zero_direction
// config  | csr_*   | index 0..2: cam_x, cam_y, cam_z
//
// A coefficient of index 1 and up passes the back sequencer states for squares,
// polynomial, two-part scale multiply, rounding and accumulate; after the last
// one the back loads the result register once it is free. Index 0 goes through
// the front: range shift, sum of squares, bit-serial root, three 16-step
// divisions, queue write. The queue lets the back drain the previous splat
// meanwhile. Reset is synchronous and clears control state, sums and direction.
// Either side may stall at any time; results wait in the output register while
// the next items are taken.
module sh_degree3_color_eval #(
   parameter int SH_DEGREE   = sh3ce_pkg::SH_DEGREE_DEF,
   parameter int QUEUE_DEPTH = sh3ce_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // pos_x, pos_y, pos_z, coef_index, coef_r, coef_g, coef_b, zero pad
   input  logic [sh3ce_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // color_r, color_g, color_b
   output logic [sh3ce_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // zero_direction
   output logic                                rsp_tuser,
   input  logic                                csr_we,
   input  logic [sh3ce_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [sh3ce_pkg::POS_W-1:0]         csr_wdata
);
   import sh3ce_pkg::*;

   logic signed [POS_W-1:0] cam_x_ff, cam_x_in, cam_y_ff, cam_y_in, cam_z_ff, cam_z_in;
   logic                    push_valid, pop;
   entry_type               push_entry, pop_entry;
   queue_status_type        q_status;
   logic [COLOR_W-1:0]      color_r, color_g, color_b;

   // Camera registers
   always_comb begin
      cam_x_in = cam_x_ff;
      cam_y_in = cam_y_ff;
      cam_z_in = cam_z_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_CAM_X: cam_x_in = csr_wdata;
            CSR_CAM_Y: cam_y_in = csr_wdata;
            CSR_CAM_Z: cam_z_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_x_ff <= '0;
         cam_y_ff <= '0;
         cam_z_ff <= '0;
      end else begin
         cam_x_ff <= cam_x_in;
         cam_y_ff <= cam_y_in;
         cam_z_ff <= cam_z_in;
      end
   end

   sh3ce_front #(.SH_DEGREE(SH_DEGREE)) u_front (
      .clock      (clock),
      .reset      (reset),
      .cam_x      (cam_x_ff),
      .cam_y      (cam_y_ff),
      .cam_z      (cam_z_ff),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .pos_x      ($signed(req_tdata[31:0])),
      .pos_y      ($signed(req_tdata[63:32])),
      .pos_z      ($signed(req_tdata[95:64])),
      .coef_index (req_tdata[99:96]),
      .coef_r     ($signed(req_tdata[115:100])),
      .coef_g     ($signed(req_tdata[131:116])),
      .coef_b     ($signed(req_tdata[147:132])),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .q_status   (q_status)
   );

   sh3ce_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .status     (q_status)
   );

   sh3ce_back #(.SH_DEGREE(SH_DEGREE)) u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_entry      (pop_entry),
      .q_status       (q_status),
      .pop            (pop),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .color_r        (color_r),
      .color_g        (color_g),
      .color_b        (color_b),
      .zero_direction (rsp_tuser)
   );

   assign rsp_tdata = {color_b, color_g, color_r};

endmodule
`default_nettype wire

// ----- rtl/sh3ce_checker.sv -----
`default_nettype none
`include "sh_degree3_color_eval_assert.svh"
module sh3ce_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [sh3ce_pkg::REQ_DATA_W-1:0]  req_tdata,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [sh3ce_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                              rsp_tuser
);
   // A stalled result keeps its payload
   `SH3CE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   // No result right after reset
   `SH3CE_ASSERT_AFTER_RESET(a_rsp_reset, clock, reset, !rsp_tvalid)
   // An index 0 transaction starts the direction unit, so the front is busy next
   `SH3CE_ASSERT_NEXT(a_dir_busy, clock, reset, req_tvalid && req_tready && req_tdata[99:96] == 4'd0, !req_tready)
endmodule

bind sh_degree3_color_eval sh3ce_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
